FILE: rtl/h264_start_code_header_capture_unit_defines.svh
// Assertion macros shared by the start code parser RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef H264_START_CODE_HEADER_CAPTURE_UNIT_DEFINES_SVH
`define H264_START_CODE_HEADER_CAPTURE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check that must hold at every clock edge out of reset.
`define H264SC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("h264sc check failed");
// Check that a condition in one cycle implies another in the next.
`define H264SC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("h264sc sequence check failed");
`else
`define H264SC_ASSERT(label, cond)
`define H264SC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/h264sc_pkg.sv
// Package for the start code parser: sizes, NAL type codes, mode codes and
// the structs passed between the scanner and the top level. No dependencies.
package h264sc_pkg;

  // Store size and scan position width
  localparam int HEADER_BYTES = 256;
  localparam int POS_BITS     = 24;

  localparam int IDX_W     = $clog2(HEADER_BYTES);
  localparam int ADDR_W    = IDX_W + 1;                 // bank bit + byte index
  localparam int LEN_W     = $clog2(HEADER_BYTES + 1);
  localparam int COUNT_CAP = HEADER_BYTES + 5;
  localparam int CNT_W     = $clog2(COUNT_CAP + 1);

  // Port field widths
  localparam int MODE_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int TYPE_W    = 5;
  localparam int OFFSET_W  = 24;
  localparam int LEN_OUT_W = 9;
  localparam int RD_CMP_W  = (LEN_W > BYTE_W) ? LEN_W : BYTE_W;

  localparam logic [POS_BITS-1:0] POS_MAX    = '1;
  localparam logic [31:0]         START_WORD = 32'h0000_0001;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_STREAM   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_READ_SPS = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_READ_PPS = MODE_W'(2);

  // Result kinds
  localparam logic RESULT_SUMMARY = 1'b0;
  localparam logic RESULT_READ    = 1'b1;

  // NAL unit types of interest
  localparam logic [TYPE_W-1:0] NAL_NONIDR = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] NAL_IDR    = TYPE_W'(5);
  localparam logic [TYPE_W-1:0] NAL_SPS    = TYPE_W'(7);
  localparam logic [TYPE_W-1:0] NAL_PPS    = TYPE_W'(8);

  // Committed header lengths and the bank that holds each committed unit
  typedef struct packed {
    logic [LEN_W-1:0] sps_len;
    logic [LEN_W-1:0] pps_len;
    logic             sps_sel;
    logic             pps_sel;
  } hdr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  // End-of-buffer report
  typedef struct packed {
    logic                 found;
    logic [OFFSET_W-1:0]  offset;
    logic [TYPE_W-1:0]    ftype;
    logic [LEN_OUT_W-1:0] sps_len;
    logic [LEN_OUT_W-1:0] pps_len;
    logic                 overflow;
  } summary_t;

endpackage

FILE: rtl/h264_start_code_header_capture_unit.sv
// Top level of the Annex B start code parser with SPS/PPS capture.
// Uses h264sc_pkg, h264sc_scan, h264sc_ram and the shared assertion macros.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, in_mode, in_data_byte,       | into block
//           | in_last_byte, in_read_index                      |
//   out     | out_valid, out_stall, out_result_kind, out_frame_*,| out of block
//           | out_sps/pps_length, out_header_overflow, out_read_data |
//
// One item per clock unless a result waits on out_stall: an item taken at
// an edge sits in the input register, is processed by the scanner or a
// store read, and lands in the result register at the edge on which it
// fires, where its result is offered. Store reads use the registered
// RAM port. Reset is synchronous; the header stores need no clearing pass
// because nothing beyond a committed length is ever read.
// out_stall holds only items that produce a result; plain stream bytes keep
// flowing through the scanner while a result waits.
`include "h264_start_code_header_capture_unit_defines.svh"

module h264_start_code_header_capture_unit
  import h264sc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_last_byte,
  input  logic [BYTE_W-1:0]    in_read_index,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_result_kind,
  output logic                 out_frame_found,
  output logic [OFFSET_W-1:0]  out_frame_offset,
  output logic [TYPE_W-1:0]    out_frame_type,
  output logic [LEN_OUT_W-1:0] out_sps_length,
  output logic [LEN_OUT_W-1:0] out_pps_length,
  output logic                 out_header_overflow,
  output logic [BYTE_W-1:0]    out_read_data
);

  // input register
  logic              in_valid_r, in_valid_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [BYTE_W-1:0] data_r;
  logic              last_r;
  logic [BYTE_W-1:0] index_r;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  logic                 out_found_r;
  logic [OFFSET_W-1:0]  out_offset_r;
  logic [TYPE_W-1:0]    out_type_r;
  logic [LEN_OUT_W-1:0] out_sps_len_r;
  logic [LEN_OUT_W-1:0] out_pps_len_r;
  logic                 out_ovf_r;
  logic                 out_use_ram_r;
  logic                 out_from_pps_r;
  logic [BYTE_W-1:0]    out_const_r;

  logic in_take, is_read, is_stream, makes_result, out_free, fire, scan_step;
  logic in_range, use_ram, sps_rd_en, pps_rd_en;
  logic [LEN_W-1:0]  rd_len;
  logic [BYTE_W-1:0] const_byte;
  logic [BYTE_W-1:0] sps_q, pps_q;

  hdr_t     hdr;
  ram_wr_t  sps_wr, pps_wr;
  summary_t summary;

  // ---------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------
  always_comb begin
    is_read      = (mode_r == MODE_READ_SPS) || (mode_r == MODE_READ_PPS);
    is_stream    = (mode_r == MODE_STREAM);
    makes_result = is_read || (is_stream && last_r);
    out_free     = !out_valid_r || !out_stall;
    fire         = in_valid_r && (out_free || !makes_result);
    scan_step    = fire && is_stream;
    in_take      = in_valid && !in_stall;

    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end

    if (fire && makes_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall = in_valid_r && !fire;

  // ---------------------------------------------------------------------
  // Store read: bytes 0..3 of any committed unit are the start code itself,
  // so only the type byte onwards comes from the RAM
  // ---------------------------------------------------------------------
  always_comb begin
    rd_len     = (mode_r == MODE_READ_PPS) ? hdr.pps_len : hdr.sps_len;
    in_range   = RD_CMP_W'(index_r) < RD_CMP_W'(rd_len);
    use_ram    = in_range && (index_r >= BYTE_W'(4));
    const_byte = (in_range && index_r == BYTE_W'(3)) ? BYTE_W'(1) : '0;
    sps_rd_en  = fire && (mode_r == MODE_READ_SPS) && use_ram;
    pps_rd_en  = fire && (mode_r == MODE_READ_PPS) && use_ram;
  end

  h264sc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (scan_step),
    .data_byte (data_r),
    .last_byte (last_r),
    .hdr       (hdr),
    .sps_wr    (sps_wr),
    .pps_wr    (pps_wr),
    .summary   (summary)
  );

  h264sc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 * HEADER_BYTES)
  ) u_sps_ram (
    .clk     (clk),
    .wr_en   (sps_wr.en),
    .wr_addr (sps_wr.addr),
    .wr_data (sps_wr.data),
    .rd_en   (sps_rd_en),
    .rd_addr ({hdr.sps_sel, IDX_W'(index_r)}),
    .rd_data (sps_q)
  );

  h264sc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 * HEADER_BYTES)
  ) u_pps_ram (
    .clk     (clk),
    .wr_en   (pps_wr.en),
    .wr_addr (pps_wr.addr),
    .wr_data (pps_wr.data),
    .rd_en   (pps_rd_en),
    .rd_addr ({hdr.pps_sel, IDX_W'(index_r)}),
    .rd_data (pps_q)
  );

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r  <= in_mode;
      data_r  <= in_data_byte;
      last_r  <= in_last_byte;
      index_r <= in_read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && makes_result) begin
      out_kind_r     <= is_read ? RESULT_READ : RESULT_SUMMARY;
      out_found_r    <= is_read ? 1'b0 : summary.found;
      out_offset_r   <= is_read ? '0 : summary.offset;
      out_type_r     <= is_read ? '0 : summary.ftype;
      out_sps_len_r  <= is_read ? LEN_OUT_W'(hdr.sps_len) : summary.sps_len;
      out_pps_len_r  <= is_read ? LEN_OUT_W'(hdr.pps_len) : summary.pps_len;
      out_ovf_r      <= is_read ? 1'b0 : summary.overflow;
      out_use_ram_r  <= is_read && use_ram;
      out_from_pps_r <= (mode_r == MODE_READ_PPS);
      out_const_r    <= is_read ? const_byte : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_frame_found     = out_found_r;
  assign out_frame_offset    = out_offset_r;
  assign out_frame_type      = out_type_r;
  assign out_sps_length      = out_sps_len_r;
  assign out_pps_length      = out_pps_len_r;
  assign out_header_overflow = out_ovf_r;
  assign out_read_data       = out_use_ram_r ? (out_from_pps_r ? pps_q : sps_q) : out_const_r;

  `H264SC_ASSERT_NEXT(a_result_follows, fire && makes_result, out_valid_r)
  `H264SC_ASSERT(a_read_result_clean, !(out_valid_r && out_kind_r == RESULT_READ) ||
                 (!out_found_r && !out_ovf_r && out_offset_r == '0))
  `H264SC_ASSERT(a_ram_read_when_free, !(sps_rd_en || pps_rd_en) || out_free)

endmodule

FILE: rtl/h264sc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone, no package use.
module h264sc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/h264sc_scan.sv
// Start code scanner: byte window, position, open unit, staging count and
// header commit logic. Uses h264sc_pkg and the shared assertion macros.
`include "h264_start_code_header_capture_unit_defines.svh"

module h264sc_scan
  import h264sc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output hdr_t              hdr,
  output ram_wr_t           sps_wr,
  output ram_wr_t           pps_wr,
  output summary_t          summary
);

  typedef struct packed {
    hdr_t h;
    logic ovf;
  } close_t;

  // Close the open unit: commit an SPS or PPS to its store, or flag it if too long
  function automatic close_t close_unit(close_t c, logic [TYPE_W-1:0] utype,
                                        logic [CNT_W-1:0] len);
    close_t r;
    r = c;
    if (utype == NAL_SPS || utype == NAL_PPS) begin
      if (len > CNT_W'(HEADER_BYTES)) begin
        r.ovf = 1'b1;
      end else if (utype == NAL_SPS) begin
        r.h.sps_sel = ~c.h.sps_sel;
        r.h.sps_len = LEN_W'(len);
      end else begin
        r.h.pps_sel = ~c.h.pps_sel;
        r.h.pps_len = LEN_W'(len);
      end
    end
    return r;
  endfunction

  logic [31:0]         window_r, window_nxt, window_upd;
  logic [POS_BITS-1:0] pos_r, pos_nxt, pos_upd;
  logic [TYPE_W-1:0]   open_r, open_nxt, open_upd;
  logic                stopped_r, stopped_nxt, stopped_upd;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_upd;
  logic                ovf_r, ovf_nxt;
  hdr_t                hdr_r, hdr_nxt;

  logic              running, det, frame, wr_ok;
  logic [TYPE_W-1:0] nal_type;
  logic [IDX_W-1:0]  wr_idx;
  close_t            c_det, c_end;

  always_comb begin
    running  = ~stopped_r;
    det      = running && (pos_r >= POS_BITS'(4)) && (window_r == START_WORD);
    nal_type = data_byte[TYPE_W-1:0];
    frame    = det && (nal_type == NAL_IDR || nal_type == NAL_NONIDR);

    // a start code ends the previous unit; its own four bytes are not counted
    c_det = '{h: hdr_r, ovf: ovf_r};
    if (det) begin
      c_det = close_unit(c_det, open_r,
                         (cnt_r >= CNT_W'(4)) ? cnt_r - CNT_W'(4) : '0);
    end

    open_upd    = det ? nal_type : open_r;
    stopped_upd = stopped_r | frame;

    if (det) begin
      cnt_upd = frame ? '0 : CNT_W'(5);
    end else if (running && cnt_r < CNT_W'(COUNT_CAP)) begin
      cnt_upd = cnt_r + CNT_W'(1);
    end else begin
      cnt_upd = cnt_r;
    end

    window_upd = running ? {window_r[23:0], data_byte} : window_r;
    pos_upd    = (running && !stopped_upd && pos_r != POS_MAX) ?
                 pos_r + POS_BITS'(1) : pos_r;

    // bytes 0..3 of a stored unit are always the start code, so only the
    // type byte (index 4) is written on a start code
    wr_idx = det ? IDX_W'(4) : IDX_W'(cnt_r);
    wr_ok  = step && running && !frame && (det || cnt_r < CNT_W'(HEADER_BYTES));

    sps_wr.en   = wr_ok && (open_upd == NAL_SPS);
    sps_wr.addr = {~c_det.h.sps_sel, wr_idx};
    sps_wr.data = data_byte;
    pps_wr.en   = wr_ok && (open_upd == NAL_PPS);
    pps_wr.addr = {~c_det.h.pps_sel, wr_idx};
    pps_wr.data = data_byte;

    // end of buffer: a unit still open runs to the last byte
    c_end = stopped_upd ? c_det : close_unit(c_det, open_upd, cnt_upd);

    summary.found    = stopped_upd;
    summary.offset   = OFFSET_W'((pos_upd >= POS_BITS'(4)) ? pos_upd - POS_BITS'(4) : '0);
    summary.ftype    = stopped_upd ? open_upd : '0;
    summary.sps_len  = LEN_OUT_W'(c_end.h.sps_len);
    summary.pps_len  = LEN_OUT_W'(c_end.h.pps_len);
    summary.overflow = c_end.ovf;
  end

  always_comb begin
    window_nxt  = window_r;
    pos_nxt     = pos_r;
    open_nxt    = open_r;
    stopped_nxt = stopped_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    hdr_nxt     = hdr_r;
    if (step) begin
      if (last_byte) begin
        window_nxt  = '0;
        pos_nxt     = '0;
        open_nxt    = '0;
        stopped_nxt = 1'b0;
        cnt_nxt     = '0;
        ovf_nxt     = 1'b0;
        hdr_nxt     = c_end.h;
      end else begin
        window_nxt  = window_upd;
        pos_nxt     = pos_upd;
        open_nxt    = open_upd;
        stopped_nxt = stopped_upd;
        cnt_nxt     = cnt_upd;
        ovf_nxt     = c_det.ovf;
        hdr_nxt     = c_det.h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      pos_r     <= '0;
      open_r    <= '0;
      stopped_r <= 1'b0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      hdr_r     <= '0;
    end else begin
      window_r  <= window_nxt;
      pos_r     <= pos_nxt;
      open_r    <= open_nxt;
      stopped_r <= stopped_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      hdr_r     <= hdr_nxt;
    end
  end

  assign hdr = hdr_r;

  `H264SC_ASSERT(a_one_store_write, !(sps_wr.en && pps_wr.en))
  `H264SC_ASSERT(a_len_bounded, (hdr_r.sps_len <= LEN_W'(HEADER_BYTES)) && (hdr_r.pps_len <= LEN_W'(HEADER_BYTES)))
  `H264SC_ASSERT_NEXT(a_stop_freezes_scan, stopped_r && !(step && last_byte), stopped_r && $stable(pos_r) && $stable(window_r))

endmodule

FILE: test/h264_start_code_header_capture_unit_tb.sv
// Self-checking testbench for h264_start_code_header_capture_unit.
// Depends on h264sc_pkg and the block's RTL; an internal predictor works out
// every summary and read.
module h264_start_code_header_capture_unit_tb;
  import h264sc_pkg::*;

  localparam int TIMEOUT_UNITS = 1_000_000;
  localparam int FIRST_GOAL    = 1000;   // items before the long hold-off
  localparam int ITEM_GOAL     = 1930;   // directed + random stream and read items
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 10;

  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  // one expected result item
  typedef struct packed {
    logic                 kind;
    logic                 found;
    logic [OFFSET_W-1:0]  offset;
    logic [TYPE_W-1:0]    ftype;
    logic [LEN_OUT_W-1:0] sps_len;
    logic [LEN_OUT_W-1:0] pps_len;
    logic                 overflow;
    logic [BYTE_W-1:0]    rdata;
  } capture_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;
  typedef enum {UNIT_SPS, UNIT_PPS, UNIT_FRAME, UNIT_OTHER, UNIT_BROKEN} unit_kind_t;

  // every input known from time zero
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode       = MODE_STREAM;
  logic [BYTE_W-1:0]    in_data_byte  = '0;
  logic                 in_last_byte  = 1'b0;
  logic [BYTE_W-1:0]    in_read_index = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_result_kind;
  logic                 out_frame_found;
  logic [OFFSET_W-1:0]  out_frame_offset;
  logic [TYPE_W-1:0]    out_frame_type;
  logic [LEN_OUT_W-1:0] out_sps_length;
  logic [LEN_OUT_W-1:0] out_pps_length;
  logic                 out_header_overflow;
  logic [BYTE_W-1:0]    out_read_data;

  h264_start_code_header_capture_unit u_dut (.*);

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: per-buffer scan state plus the two double-banked stores.
  // ---------------------------------------------------------------------------
  logic [31:0]          scan_window;
  logic [POS_BITS-1:0]  scan_pos;
  logic [TYPE_W-1:0]    open_type;
  logic                 scan_halted;
  int unsigned          unit_bytes;       // bytes of the open unit, start code included
  logic                 dropped_header;
  logic [BYTE_W-1:0]    sps_mem [2*HEADER_BYTES];
  logic [BYTE_W-1:0]    pps_mem [2*HEADER_BYTES];
  int unsigned          sps_held, pps_held;
  logic                 sps_bank, pps_bank; // bank holding the committed unit

  capture_result_t      expected_q[$];

  int mismatches      = 0;
  int results_checked = 0;
  int summaries_seen  = 0;
  int frames_seen     = 0;
  int overflows_seen  = 0;
  int reads_seen      = 0;

  // sender and receiver control
  int   items_sent   = 0;
  int   burst_left   = 0;
  bit   sender_gaps  = 1'b1;
  bit   hold_request = 1'b0;
  int   hold_left    = 0;
  int   style_left   = 0;
  stall_style_t stall_style = STALL_NONE;

  function automatic void clear_scan();
    scan_window    = '0;
    scan_pos       = '0;
    open_type      = '0;
    scan_halted    = 1'b0;
    unit_bytes     = 0;
    dropped_header = 1'b0;
  endfunction

  // Bytes go to the staging bank, the one not holding the committed unit.
  // Only the first HEADER_BYTES are kept; the count runs a little past to flag overflow.
  function automatic void stage_byte(input logic [BYTE_W-1:0] b);
    if (unit_bytes < HEADER_BYTES) begin
      if (open_type == NAL_SPS) sps_mem[(sps_bank ? 0 : HEADER_BYTES) + unit_bytes] = b;
      else if (open_type == NAL_PPS) pps_mem[(pps_bank ? 0 : HEADER_BYTES) + unit_bytes] = b;
    end
    if (unit_bytes < COUNT_CAP) unit_bytes++;
  endfunction

  // A finished SPS/PPS unit swaps banks, unless it outgrew the store.
  function automatic void commit_unit(input int unsigned len);
    if (open_type != NAL_SPS && open_type != NAL_PPS) return;
    if (len > HEADER_BYTES) begin
      dropped_header = 1'b1;
      return;
    end
    if (open_type == NAL_SPS) begin
      sps_bank = ~sps_bank;
      sps_held = len;
    end else begin
      pps_bank = ~pps_bank;
      pps_held = len;
    end
  endfunction

  // Works out what one accepted item does and queues its result, if any.
  function automatic void predict_capture(input logic [MODE_W-1:0] mode,
                                          input logic [BYTE_W-1:0] data,
                                          input logic last,
                                          input logic [BYTE_W-1:0] idx);
    capture_result_t     r;
    int unsigned         held;
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS:0]   total;
    logic [TYPE_W-1:0]   t;
    r = '0;
    if (mode == MODE_READ_SPS || mode == MODE_READ_PPS) begin
      held      = (mode == MODE_READ_SPS) ? sps_held : pps_held;
      r.kind    = RESULT_READ;
      r.sps_len = LEN_OUT_W'(sps_held);
      r.pps_len = LEN_OUT_W'(pps_held);
      if (idx < held) begin
        r.rdata = (mode == MODE_READ_SPS) ? sps_mem[(sps_bank ? HEADER_BYTES : 0) + idx]
                                          : pps_mem[(pps_bank ? HEADER_BYTES : 0) + idx];
      end
      expected_q.push_back(r);
      return;
    end
    if (mode != MODE_STREAM) return;

    start_pos = scan_pos;
    if (!scan_halted) begin
      if (start_pos >= 4 && scan_window == START_WORD) begin
        // type byte of a new unit: close the old one (minus the new start code)
        t = data[TYPE_W-1:0];
        commit_unit(unit_bytes >= 4 ? unit_bytes - 4 : 0);
        open_type  = t;
        unit_bytes = 0;
        if (t == NAL_IDR || t == NAL_NONIDR) begin
          scan_halted = 1'b1;
        end else begin
          stage_byte(8'h00);
          stage_byte(8'h00);
          stage_byte(8'h00);
          stage_byte(8'h01);
          stage_byte(data);
        end
      end else begin
        stage_byte(data);
      end
      scan_window = {scan_window[23:0], data};
      if (!scan_halted && scan_pos != POS_MAX) scan_pos++;
    end
    if (!last) return;

    r.kind = RESULT_SUMMARY;
    if (scan_halted) begin
      r.found  = 1'b1;
      r.offset = OFFSET_W'(scan_pos >= 4 ? scan_pos - 4 : 0);
      r.ftype  = open_type;
    end else begin
      total = start_pos + 1;
      if (total > POS_MAX) total = POS_MAX;
      commit_unit(unit_bytes);   // unit running to the buffer's end
      r.offset = OFFSET_W'(total >= 4 ? total - 4 : 0);
    end
    r.sps_len  = LEN_OUT_W'(sps_held);
    r.pps_len  = LEN_OUT_W'(pps_held);
    r.overflow = dropped_header;
    expected_q.push_back(r);
    clear_scan();
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    capture_result_t want;
    if (expected_q.size() == 0) begin
      $error("result item with no expectation waiting (kind %0d)", out_result_kind);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    results_checked++;
    if (want.kind == RESULT_READ) reads_seen++;
    else begin
      summaries_seen++;
      if (want.found) frames_seen++;
      if (want.overflow) overflows_seen++;
    end
    compare_field("result_kind", want.kind, out_result_kind);
    compare_field("frame_found", want.found, out_frame_found);
    compare_field("frame_offset", want.offset, out_frame_offset);
    compare_field("frame_type", want.ftype, out_frame_type);
    compare_field("sps_length", want.sps_len, out_sps_length);
    compare_field("pps_length", want.pps_len, out_pps_length);
    compare_field("header_overflow", want.overflow, out_header_overflow);
    compare_field("read_data", want.rdata, out_read_data);
  endfunction

  // Both handshakes sampled at the edge on pre-edge values; the result is
  // checked before the new item is predicted (latency keeps them apart).
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      sps_held = 0;
      pps_held = 0;
      sps_bank = 1'b0;
      pps_bank = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall)
        predict_capture(in_mode, in_data_byte, in_last_byte, in_read_index);
    end
  end

  // Receiver: changes its stall style every so often; a hold-off request
  // overrides it until hold_left, loaded from HOLD_CYCLES and counted here, runs out.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(16, 160);
    end
    style_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Sender: items go out in bursts of random length; between bursts, when gaps are on,
  // valid drops for a random gap with junk on the payload. Called just after an edge.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                           input logic last, input logic [BYTE_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (sender_gaps && $urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid      <= 1'b0;
        in_mode       <= MODE_W'($urandom);
        in_data_byte  <= BYTE_W'($urandom);
        in_last_byte  <= 1'($urandom);
        in_read_index <= BYTE_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_data_byte  <= data;
    in_last_byte  <= last;
    in_read_index <= idx;
    if (mode != MODE_UNUSED) items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Store read: index mostly low, sometimes at the top of the store.
  task automatic send_read();
    logic [BYTE_W-1:0] idx;
    case ($urandom_range(0, 3))
      0, 1:    idx = BYTE_W'($urandom_range(0, 15));
      2:       idx = BYTE_W'($urandom);
      default: idx = BYTE_W'($urandom_range(240, 255));
    endcase
    send_item($urandom_range(0, 1) ? MODE_READ_SPS : MODE_READ_PPS,
              BYTE_W'($urandom), 1'($urandom), idx);
  endtask

  // One buffer, last_byte on its final byte; reads and unused-mode items
  // can be mixed in between the bytes.
  task automatic send_buffer(input byte_q_t bytes_in, input bit with_reads);
    foreach (bytes_in[i]) begin
      if (with_reads && $urandom_range(0, 11) == 0) send_read();
      if (with_reads && $urandom_range(0, 99) == 0)
        send_item(MODE_UNUSED, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
      send_item(MODE_STREAM, bytes_in[i], i == bytes_in.size() - 1, BYTE_W'($urandom));
    end
  endtask

  // Mostly well-formed buffers: optional leading bytes, then units with
  // start codes, SPS/PPS bodies now and then near or past the store size.
  // A tenth are noise rich in 00 and 01 bytes.
  task automatic send_random_buffer();
    byte_q_t    bytes_q;
    unit_kind_t kind;
    int         pick;
    int         body;
    logic [TYPE_W-1:0] t;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) begin
        pick = $urandom_range(0, 3);
        bytes_q.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'h01 : BYTE_W'($urandom));
        if (pick == 2) bytes_q.push_back(8'h00);
      end
    end else begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) bytes_q.push_back(BYTE_W'($urandom));
      repeat ($urandom_range(0, 5)) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) kind = UNIT_SPS;
        else if (pick < 12) kind = UNIT_PPS;
        else if (pick < 15) kind = UNIT_FRAME;
        else if (pick < 19) kind = UNIT_OTHER;
        else kind = UNIT_BROKEN;
        if (kind == UNIT_BROKEN) begin
          // three-byte start code: not a unit boundary here
          bytes_q.push_back(8'h00);
          bytes_q.push_back(8'h00);
          bytes_q.push_back(8'h01);
          bytes_q.push_back(BYTE_W'($urandom));
        end else begin
          if ($urandom_range(0, 9) == 0) bytes_q.push_back(8'h00);
          bytes_q.push_back(8'h00);
          bytes_q.push_back(8'h00);
          bytes_q.push_back(8'h00);
          bytes_q.push_back(8'h01);
          case (kind)
            UNIT_SPS:   t = NAL_SPS;
            UNIT_PPS:   t = NAL_PPS;
            UNIT_FRAME: t = $urandom_range(0, 1) ? NAL_IDR : NAL_NONIDR;
            default:    t = TYPE_W'($urandom);
          endcase
          bytes_q.push_back({3'($urandom), t});
        end
        // unit length is body + 5; 245..260 straddles the store size
        if ((kind == UNIT_SPS || kind == UNIT_PPS) && $urandom_range(0, 9) == 0)
          body = $urandom_range(245, 260);
        else
          body = $urandom_range(0, 24);
        repeat (body) bytes_q.push_back(BYTE_W'($urandom));
      end
      if (bytes_q.size() == 0) bytes_q.push_back(BYTE_W'($urandom));
    end
    send_buffer(bytes_q, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty stores read back zero at both ends of the index range; mode 3 is dropped.
  task automatic test_reads_after_reset();
    send_item(MODE_READ_SPS, 8'h00, 1'b0, 8'h00);
    send_item(MODE_READ_PPS, 8'hFF, 1'b1, 8'hFF);
    send_item(MODE_UNUSED, 8'hFF, 1'b1, 8'h00);
  endtask

  task automatic test_directed_scan();
    // shorter than a start code: offset clamps to zero
    send_buffer('{8'hFF}, 1'b0);
    // start code within the first four bytes is not recognised
    send_buffer('{8'h00, 8'h00, 8'h01, 8'h67}, 1'b0);
    // stray byte, SPS, PPS (upper type bits set), IDR frame, byte after the frame
    send_buffer('{8'h5A, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h01, 8'hE8,
                  8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00}, 1'b0);
    // stored bytes, and reads just past each stored length
    send_item(MODE_READ_SPS, 8'h00, 1'b0, 8'h04);
    send_item(MODE_READ_SPS, 8'h00, 1'b0, 8'h06);
    send_item(MODE_READ_PPS, 8'h00, 1'b0, 8'h04);
    send_item(MODE_READ_PPS, 8'h00, 1'b0, 8'h05);
    // non-IDR frame whose type byte is the last byte
    send_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'h41}, 1'b0);
  endtask

  task automatic test_random_buffers(input int goal);
    while (items_sent < goal) begin
      sender_gaps = ($urandom_range(0, 3) != 0);   // some buffers go back to back
      send_random_buffer();
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver holds off for a long stretch while reads keep coming, so the
  // result path fills and in_stall has to rise.
  task automatic test_output_hold_off();
    sender_gaps  = 1'b0;
    burst_left   = 0;
    hold_request = 1'b1;
    repeat (48) send_read();
    send_item(MODE_STREAM, BYTE_W'($urandom), 1'b1, BYTE_W'($urandom));
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reads_after_reset();
    test_directed_scan();
    test_random_buffers(FIRST_GOAL);
    test_output_hold_off();
    test_random_buffers(ITEM_GOAL);

    in_valid <= 1'b0;
    // let the checker predict the final item before watching the queue
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d results checked: %0d buffer summaries, %0d store reads",
             items_sent, results_checked, summaries_seen, reads_seen);
    $display("buffers with a frame: %0d, with a dropped header: %0d",
             frames_seen, overflows_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: generous bound on the slowest legal run
  initial begin
    #TIMEOUT_UNITS;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/h264sc_pkg.sv
rtl/h264sc_ram.sv
rtl/h264sc_scan.sv
rtl/h264_start_code_header_capture_unit.sv
test/h264_start_code_header_capture_unit_tb.sv
